@@ src/tcp_segment_checksum_check_unit_macros.svh @@
// Assertion macros shared by the checksum checker.
`ifndef TCP_SEGMENT_CHECKSUM_CHECK_UNIT_MACROS_SVH
`define TCP_SEGMENT_CHECKSUM_CHECK_UNIT_MACROS_SVH

// Concurrent check on the rising clock, quiet while reset is held.
`define TCPCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define TCPCK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `TCPCK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ src/tcpck_pkg.sv @@
package tcpck_pkg;

  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned OFFSET_BYTE  = 12;
  localparam int unsigned COUNT_W      = 17;

  localparam logic [15:0] PROTO_TCP = 16'd6;
  localparam logic [15:0] WORD_MASK = 16'hFFFF;

  localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd1;
  localparam logic [2:0] VERDICT_BAD_OFFSET = 3'd2;
  localparam logic [2:0] VERDICT_TOO_LONG   = 3'd3;
  localparam logic [2:0] VERDICT_BAD_SUM    = 3'd4;

  // One registered input item: the byte, its end mark and the
  // pseudo-header seed already folded from the two addresses and protocol.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] seed;
  } item_t;

  // Fold a sum of up to eight 16-bit words into a one's-complement word.
  function automatic logic [15:0] oc_fold(input logic [18:0] total);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return s2[15:0];
  endfunction

endpackage

@@ src/tcpck_in_stage.sv @@
module tcpck_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output tcpck_pkg::item_t    item_o
);
  import tcpck_pkg::*;

  logic        valid_q;
  logic        valid_d;
  item_t       item_q;
  logic        load;
  logic [18:0] seed_total;

  // Pseudo-header words: both addresses and the protocol number.
  assign seed_total = {3'd0, src_addr_i[31:16]} + {3'd0, src_addr_i[15:0]}
                    + {3'd0, dst_addr_i[31:16]} + {3'd0, dst_addr_i[15:0]}
                    + {3'd0, PROTO_TCP};

  assign in_ready_o = !valid_q || item_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte <= data_byte_i;
      item_q.last_byte <= last_byte_i;
      item_q.seed      <= oc_fold(seed_total);
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ src/tcpck_core.sv @@
module tcpck_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  tcpck_pkg::item_t    item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic [15:0]         checksum_value_o,
  output logic [2:0]          verdict_o,
  output logic [15:0]         segment_length_o
);
  import tcpck_pkg::*;

  logic [15:0]        sum_q, sum_d;
  logic [7:0]         pend_q, pend_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]         offset_q, offset_d;
  logic               res_valid_q, res_valid_d;
  logic [15:0]        cks_q;
  logic [2:0]         verdict_q;
  logic [15:0]        len_q;

  logic               advance;
  logic               cnt_sat;
  logic [15:0]        base;
  logic [15:0]        word;
  logic [COUNT_W-1:0] cnt_next;
  logic [15:0]        seg_len;
  logic [15:0]        len_term;
  logic [18:0]        total;
  logic [15:0]        sum_new;
  logic [15:0]        cks;
  logic [3:0]         offset_new;
  logic [COUNT_W-1:0] doff;
  logic [2:0]         verdict;

  // An item with no result never waits on the result register.
  assign item_ready_o = !item_i.last_byte || !res_valid_q || res_ready_i;
  assign advance      = item_valid_i && item_ready_o;

  assign cnt_sat  = cnt_q[COUNT_W-1];
  assign base     = (cnt_q == '0) ? item_i.seed : sum_q;
  assign cnt_next = cnt_sat ? cnt_q : cnt_q + COUNT_W'(1);
  assign seg_len  = cnt_next[COUNT_W-1] ? WORD_MASK : cnt_next[15:0];
  assign len_term = item_i.last_byte ? seg_len : 16'd0;

  always_comb begin
    word = 16'd0;
    if (!cnt_sat) begin
      if (cnt_q[0]) begin
        word = {pend_q, item_i.data_byte};
      end else if (item_i.last_byte) begin
        word = {item_i.data_byte, 8'd0};
      end
    end
  end

  assign total      = {3'd0, base} + {3'd0, word} + {3'd0, len_term};
  assign sum_new    = oc_fold(total);
  assign cks        = ~sum_new;
  assign offset_new = (cnt_q == COUNT_W'(OFFSET_BYTE)) ? item_i.data_byte[7:4] : offset_q;
  assign doff       = {{(COUNT_W-6){1'b0}}, offset_new, 2'b00};

  always_comb begin
    if (cnt_next < COUNT_W'(HEADER_BYTES)) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (doff < COUNT_W'(HEADER_BYTES) || doff > cnt_next) begin
      verdict = VERDICT_BAD_OFFSET;
    end else if (cnt_next[COUNT_W-1]) begin
      verdict = VERDICT_TOO_LONG;
    end else if (cks != 16'd0) begin
      verdict = VERDICT_BAD_SUM;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  always_comb begin
    sum_d    = sum_q;
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    offset_d = offset_q;
    if (advance) begin
      if (item_i.last_byte) begin
        sum_d    = 16'd0;
        pend_d   = 8'd0;
        cnt_d    = '0;
        offset_d = 4'd0;
      end else begin
        sum_d    = sum_new;
        pend_d   = (!cnt_sat && !cnt_q[0]) ? item_i.data_byte : pend_q;
        cnt_d    = cnt_next;
        offset_d = offset_new;
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance && item_i.last_byte) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= 16'd0;
      pend_q      <= 8'd0;
      cnt_q       <= '0;
      offset_q    <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      offset_q    <= offset_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_i.last_byte) begin
      cks_q     <= cks;
      verdict_q <= verdict;
      len_q     <= seg_len;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign checksum_value_o = cks_q;
  assign verdict_o        = verdict_q;
  assign segment_length_o = len_q;

endmodule

@@ src/tcp_segment_checksum_check_unit.sv @@
// TCP segment checksum checker. A segment enters one byte per item in wire
// order, with the IPv4 source and destination addresses alongside; the
// addresses are used only on the first byte of a segment, where they and
// protocol 6 seed a 16-bit one's-complement sum. Bytes pair into big-endian
// words, an odd final byte is padded with a zero low byte, and the high
// nibble of byte 12 is kept as the data offset. The item marked with tlast
// closes the segment: the length (saturated at 65535) is added as the last
// pseudo-header word and one result item carries the complemented checksum,
// the verdict and the length. Verdicts, first match wins: too short (under
// 20 bytes), bad data offset (offset*4 under 20 or beyond the length), too
// long (over 65535 bytes, later bytes are not summed), checksum not zero,
// otherwise accept. Items that are not last give no result. The block takes
// one item per clock with no gaps unless a last byte stalls as below; each
// item crosses an input register and one end-around add into the running
// sum, and a last byte leaving the input register loads the result register.
// The single result register lets the bytes of the next segment keep
// flowing while a result waits to be taken; only a second last byte stalls
// until the first result leaves.
module tcp_segment_checksum_check_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // checksum_value[15:0], verdict[18:16],
                                       // segment_length[34:19], zero[39:35]
);
  import tcpck_pkg::*;

  `include "tcp_segment_checksum_check_unit_macros.svh"

  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic [15:0] checksum_value;
  logic [2:0]  verdict;
  logic [15:0] segment_length;

  tcpck_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .last_byte_i  (s_axis_tlast_i),
    .src_addr_i   (s_axis_tdata_i[39:8]),
    .dst_addr_i   (s_axis_tdata_i[71:40]),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  tcpck_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (item_valid),
    .item_ready_o     (item_ready),
    .item_i           (item),
    .res_valid_o      (m_axis_tvalid_o),
    .res_ready_i      (m_axis_tready_i),
    .checksum_value_o (checksum_value),
    .verdict_o        (verdict),
    .segment_length_o (segment_length)
  );

  assign m_axis_tdata_o = {5'd0, segment_length, verdict, checksum_value};

  // An accepted segment must have a zero checksum and a full header.
  `TCPCK_ASSERT_IMPLIES(a_accept_clean, m_axis_tvalid_o && verdict == VERDICT_ACCEPT, checksum_value == 16'd0 && segment_length >= 16'(HEADER_BYTES), "accept verdict with bad sum or length")
  // A short segment is always reported as too short, whatever else holds.
  `TCPCK_ASSERT_IMPLIES(a_short_first, m_axis_tvalid_o && segment_length < 16'(HEADER_BYTES), verdict == VERDICT_TOO_SHORT, "short segment not flagged first")
  // A new result only follows a last item leaving the input register.
  `TCPCK_ASSERT(a_result_from_last, $rose(m_axis_tvalid_o) |-> $past(item_valid && item_ready && item.last_byte), "result without a last byte")
  // The input register never drops an item that the core has not taken.
  `TCPCK_ASSERT(a_item_held, (item_valid && !item_ready) |=> item_valid, "pending item lost")

endmodule
